### rtl/core/ffha_pkg.sv
// Shared types, constants and helpers for the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffha_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int HEADER_BYTES = 24;
  localparam int ARENA_BYTES  = 1048576;
  localparam int START_W      = 20;
  localparam int SIZE_W       = 21;
  localparam int SUM_W        = 48;
  localparam int STATUS_W     = 3;
  localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(1048576);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_ZERO_SIZE    = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_NULL         = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_UNKNOWN      = 3'd5
  } status_e;

  // One segment table entry.
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [START_W-1:0] start;
  } entry_t;

  // Table read address select.
  typedef enum logic [1:0] {
    RD_PTR  = 2'd0,
    RD_NEXT = 2'd1,
    RD_PREV = 2'd2
  } rd_sel_e;

  // Table write select: address and data source.
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_UP     = 3'd1,
    WR_DOWN   = 3'd2,
    WR_SPLIT  = 3'd3,
    WR_CUR    = 3'd4,
    WR_APPEND = 3'd5
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    ptr_last;
    logic    ptr_down;
    logic    hit_take;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    split_cut;
    logic    merge_next;
    logic    merge_prev;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    append;
    logic    asum_add;
    logic    fsum_add;
    logic    act_inc;
    logic    act_dec;
    logic    st_set;
    status_e st;
    logic    emit;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic req_zero;
    logic off_zero;
    logic mode_free;
    logic scan_end;
    logic alloc_fit;
    logic free_match;
    logic rd_free;
    logic split_ok;
    logic append_ok;
    logic up_done;
    logic down_done;
    logic has_next;
    logic has_prev;
    logic emit_ok;
  } stat_t;

  // Saturating add of a byte count to a running total.
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator over a 64-entry address-ordered segment table.
// The table is walked one entry at a time, each entry read and then checked
// or moved. One transaction is handled at a time; the next is accepted in the
// cycle after the result is issued. Reset: table empty, break, counts and
// totals zero, arena_limit 1048576; the table memory itself is not cleared.
module first_fit_heap_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffha_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [ffha_pkg::SIZE_W-1:0]   request_bytes_i,
  input  logic [ffha_pkg::START_W-1:0]  release_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffha_pkg::STATUS_W-1:0] status_o,
  output logic [ffha_pkg::START_W-1:0]  payload_offset_o,
  output logic [ffha_pkg::CNT_W-1:0]    active_count_o,
  output logic [ffha_pkg::SUM_W-1:0]    bytes_allocated_total_o,
  output logic [ffha_pkg::SUM_W-1:0]    bytes_freed_total_o
);
  import ffha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, registers and result stage.
  ffha_datapath u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .mode_i                  (mode_i),
    .request_bytes_i         (request_bytes_i),
    .release_offset_i        (release_offset_i),
    .cmd_i                   (cmd),
    .stat_o                  (stat),
    .out_stall_i             (out_stall_i),
    .out_valid_o             (out_valid_o),
    .status_o                (status_o),
    .payload_offset_o        (payload_offset_o),
    .active_count_o          (active_count_o),
    .bytes_allocated_total_o (bytes_allocated_total_o),
    .bytes_freed_total_o     (bytes_freed_total_o)
  );

endmodule

### rtl/core/ffha_datapath.sv
// Datapath of the first-fit heap allocator: segment table memory, work
// registers, arena break, counters, totals and the result register. Uses ffha_pkg.
module ffha_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffha_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                          mode_i,
  input  logic [ffha_pkg::SIZE_W-1:0]   request_bytes_i,
  input  logic [ffha_pkg::START_W-1:0]  release_offset_i,
  input  ffha_pkg::cmd_t                cmd_i,
  output ffha_pkg::stat_t               stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [ffha_pkg::STATUS_W-1:0] status_o,
  output logic [ffha_pkg::START_W-1:0]  payload_offset_o,
  output logic [ffha_pkg::CNT_W-1:0]    active_count_o,
  output logic [ffha_pkg::SUM_W-1:0]    bytes_allocated_total_o,
  output logic [ffha_pkg::SUM_W-1:0]    bytes_freed_total_o
);
  import ffha_pkg::*;

  localparam logic [SIZE_W-1:0] Hdr = SIZE_W'(HEADER_BYTES);

  entry_t             mem_q [MAX_SEGMENTS];
  entry_t             rdata_q;
  logic [SIZE_W-1:0]  limit_q;
  logic               mode_q;
  logic [SIZE_W-1:0]  req_q;
  logic [START_W-1:0] off_q;
  logic [CNT_W-1:0]   ptr_q;
  logic [IDX_W-1:0]   hit_q;
  logic [CNT_W-1:0]   count_q;
  logic [SIZE_W-1:0]  brk_q;
  logic [CNT_W-1:0]   active_q;
  logic [SUM_W-1:0]   asum_q;
  logic [SUM_W-1:0]   fsum_q;
  logic [START_W-1:0] cur_start_q;
  logic [SIZE_W-1:0]  cur_size_q;
  status_e            st_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [START_W-1:0]   out_pay_q;
  logic [CNT_W-1:0]     out_active_q;
  logic [SUM_W-1:0]     out_asum_q;
  logic [SUM_W-1:0]     out_fsum_q;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [SIZE_W:0]    req_2h;
  logic [SIZE_W:0]    need;
  logic [SIZE_W-1:0]  limit;
  logic [START_W-1:0] pay;

  // Flags for the controller.
  always_comb begin
    req_2h = {1'b0, req_q} + (SIZE_W + 1)'(2 * HEADER_BYTES);
    need   = {1'b0, brk_q} + {1'b0, Hdr} + {1'b0, req_q};
    limit  = (limit_q < SIZE_W'(ARENA_BYTES)) ? limit_q : SIZE_W'(ARENA_BYTES);
    stat_o.req_zero   = (req_q == '0);
    stat_o.off_zero   = (off_q == '0);
    stat_o.mode_free  = mode_q;
    stat_o.scan_end   = (ptr_q == count_q);
    stat_o.alloc_fit  = rdata_q.free && (rdata_q.size >= req_q);
    stat_o.free_match = (({1'b0, rdata_q.start} + (START_W + 1)'(HEADER_BYTES))
                         == {1'b0, off_q});
    stat_o.rd_free    = rdata_q.free;
    stat_o.split_ok   = ({1'b0, cur_size_q} >= req_2h) &&
                        (count_q < CNT_W'(MAX_SEGMENTS));
    stat_o.append_ok  = (count_q < CNT_W'(MAX_SEGMENTS)) && (need <= {1'b0, limit});
    stat_o.up_done    = (ptr_q == {1'b0, hit_q});
    stat_o.down_done  = (ptr_q == count_q);
    stat_o.has_next   = (({1'b0, hit_q} + CNT_W'(1)) < count_q);
    stat_o.has_prev   = (hit_q != '0);
    stat_o.emit_ok    = !out_valid_q || !out_stall_i;
  end

  // Table read and write address and data selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_NEXT: rd_addr = hit_q + IDX_W'(1);
      RD_PREV: rd_addr = hit_q - IDX_W'(1);
      default: rd_addr = ptr_q[IDX_W-1:0];
    endcase
    wr_data = rdata_q;
    case (cmd_i.wr_sel)
      WR_UP:    wr_addr = ptr_q[IDX_W-1:0] + IDX_W'(1);
      WR_DOWN:  wr_addr = ptr_q[IDX_W-1:0] - IDX_W'(1);
      WR_SPLIT: begin
        wr_addr       = hit_q + IDX_W'(1);
        wr_data.free  = 1'b1;
        wr_data.start = cur_start_q + START_W'(HEADER_BYTES) + req_q[START_W-1:0];
        wr_data.size  = cur_size_q - req_q - Hdr;
      end
      WR_CUR: begin
        wr_addr       = hit_q;
        wr_data.free  = mode_q;
        wr_data.start = cur_start_q;
        wr_data.size  = cur_size_q;
      end
      WR_APPEND: begin
        wr_addr       = count_q[IDX_W-1:0];
        wr_data.free  = 1'b0;
        wr_data.start = brk_q[START_W-1:0];
        wr_data.size  = req_q;
      end
      default: wr_addr = ptr_q[IDX_W-1:0];
    endcase
  end

  // Segment table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sel != WR_NONE) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Item fields and the current segment under work.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      req_q  <= request_bytes_i;
      off_q  <= release_offset_i;
    end
    if (cmd_i.hit_take) begin
      cur_start_q <= rdata_q.start;
      cur_size_q  <= rdata_q.size;
    end else if (cmd_i.split_cut) begin
      cur_size_q <= req_q;
    end else if (cmd_i.merge_next) begin
      cur_size_q <= cur_size_q + Hdr + rdata_q.size;
    end else if (cmd_i.merge_prev) begin
      cur_start_q <= rdata_q.start;
      cur_size_q  <= rdata_q.size + Hdr + cur_size_q;
    end else if (cmd_i.append) begin
      cur_start_q <= brk_q[START_W-1:0];
    end
    if (cmd_i.st_set) begin
      st_q <= cmd_i.st;
    end
  end

  // Control registers: pointers, counts, break, totals and limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      ptr_q    <= '0;
      hit_q    <= '0;
      count_q  <= '0;
      brk_q    <= '0;
      active_q <= '0;
      asum_q   <= '0;
      fsum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_q - CNT_W'(1);
      end else if (cmd_i.ptr_last) begin
        ptr_q <= count_q - CNT_W'(1);
      end else if (cmd_i.ptr_down) begin
        ptr_q <= {1'b0, hit_q} + CNT_W'(2);
      end
      if (cmd_i.hit_take) begin
        hit_q <= ptr_q[IDX_W-1:0];
      end else if (cmd_i.merge_prev) begin
        hit_q <= hit_q - IDX_W'(1);
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.append) begin
        brk_q <= need[SIZE_W-1:0];
      end
      if (cmd_i.act_inc) begin
        active_q <= active_q + CNT_W'(1);
      end else if (cmd_i.act_dec) begin
        active_q <= active_q - CNT_W'(1);
      end
      if (cmd_i.asum_add) begin
        asum_q <= sat_add(asum_q, req_q);
      end
      if (cmd_i.fsum_add) begin
        fsum_q <= sat_add(fsum_q, cur_size_q);
      end
    end
  end

  // Result register; a granted allocation reports its payload offset.
  assign pay = ((st_q == ST_OK) && !mode_q) ? cur_start_q + START_W'(HEADER_BYTES) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= st_q;
      out_pay_q    <= pay;
      out_active_q <= active_q;
      out_asum_q   <= asum_q;
      out_fsum_q   <= fsum_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign status_o                = out_status_q;
  assign payload_offset_o        = out_pay_q;
  assign active_count_o          = out_active_q;
  assign bytes_allocated_total_o = out_asum_q;
  assign bytes_freed_total_o     = out_fsum_q;

endmodule

### rtl/core/ffha_ctrl.sv
// Controller of the first-fit heap allocator: sequences search, split,
// append, free and merge steps over the datapath. Uses ffha_pkg.
module ffha_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffha_pkg::stat_t stat_i,
  output ffha_pkg::cmd_t  cmd_o
);
  import ffha_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE       = 19'h00001,
    S_DISPATCH   = 19'h00002,
    S_SCAN_RD    = 19'h00004,
    S_SCAN_CHK   = 19'h00008,
    S_GRANT      = 19'h00010,
    S_UP_CHK     = 19'h00020,
    S_UP_WR      = 19'h00040,
    S_SPLIT_WR   = 19'h00080,
    S_GRANT_WR   = 19'h00100,
    S_APPEND     = 19'h00200,
    S_FREE_MARK  = 19'h00400,
    S_NEXT_CHK   = 19'h00800,
    S_DN_CHK     = 19'h01000,
    S_DN_WR      = 19'h02000,
    S_PREV_RD    = 19'h04000,
    S_PREV_CHK   = 19'h08000,
    S_PREV_SHIFT = 19'h10000,
    S_FREE_WR    = 19'h20000,
    S_DONE       = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          second_d   = 1'b0;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat_i.mode_free && stat_i.req_zero) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st     = ST_ZERO_SIZE;
          state_d      = S_DONE;
        end else if (stat_i.mode_free && stat_i.off_zero) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st     = ST_NULL;
          state_d      = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      // Walk the table one entry per read/check pair.
      S_SCAN_RD: begin
        if (stat_i.scan_end) begin
          if (stat_i.mode_free) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st     = ST_UNKNOWN;
            state_d      = S_DONE;
          end else begin
            state_d = S_APPEND;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR;
          state_d      = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!stat_i.mode_free && stat_i.alloc_fit) begin
          cmd_o.hit_take = 1'b1;
          state_d        = S_GRANT;
        end else if (stat_i.mode_free && stat_i.free_match) begin
          cmd_o.hit_take = 1'b1;
          if (stat_i.rd_free) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st     = ST_ALREADY_FREE;
            state_d      = S_DONE;
          end else begin
            state_d = S_FREE_MARK;
          end
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      // Allocation hit: split when the remainder holds a segment and the table has room.
      S_GRANT: begin
        if (stat_i.split_ok) begin
          cmd_o.ptr_last = 1'b1;
          state_d        = S_UP_CHK;
        end else begin
          state_d = S_GRANT_WR;
        end
      end
      S_UP_CHK: begin
        if (stat_i.up_done) begin
          state_d = S_SPLIT_WR;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR;
          state_d      = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd_o.wr_sel  = WR_UP;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_UP_CHK;
      end
      S_SPLIT_WR: begin
        cmd_o.wr_sel    = WR_SPLIT;
        cmd_o.split_cut = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = S_GRANT_WR;
      end
      S_GRANT_WR: begin
        cmd_o.wr_sel   = WR_CUR;
        cmd_o.asum_add = 1'b1;
        cmd_o.act_inc  = 1'b1;
        cmd_o.st_set   = 1'b1;
        cmd_o.st       = ST_OK;
        state_d        = S_DONE;
      end
      // No free segment fits: grow the arena at the break.
      S_APPEND: begin
        cmd_o.st_set = 1'b1;
        if (stat_i.append_ok) begin
          cmd_o.wr_sel   = WR_APPEND;
          cmd_o.append   = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.asum_add = 1'b1;
          cmd_o.act_inc  = 1'b1;
          cmd_o.st       = ST_OK;
        end else begin
          cmd_o.st = ST_NO_SPACE;
        end
        state_d = S_DONE;
      end
      // Release: count the bytes, then try both neighbors.
      S_FREE_MARK: begin
        cmd_o.fsum_add = 1'b1;
        cmd_o.act_dec  = 1'b1;
        if (stat_i.has_next) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_NEXT_CHK;
        end else begin
          state_d = S_PREV_RD;
        end
      end
      S_NEXT_CHK: begin
        if (stat_i.rd_free) begin
          cmd_o.merge_next = 1'b1;
          cmd_o.ptr_down   = 1'b1;
          state_d          = S_DN_CHK;
        end else begin
          state_d = S_PREV_RD;
        end
      end
      // Close the gap left by a merged entry.
      S_DN_CHK: begin
        if (stat_i.down_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = second_q ? S_FREE_WR : S_PREV_RD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR;
          state_d      = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd_o.wr_sel  = WR_DOWN;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_DN_CHK;
      end
      S_PREV_RD: begin
        if (stat_i.has_prev) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_PREV_CHK;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_PREV_CHK: begin
        if (stat_i.rd_free) begin
          cmd_o.merge_prev = 1'b1;
          state_d          = S_PREV_SHIFT;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_PREV_SHIFT: begin
        cmd_o.ptr_down = 1'b1;
        second_d       = 1'b1;
        state_d        = S_DN_CHK;
      end
      S_FREE_WR: begin
        cmd_o.wr_sel = WR_CUR;
        cmd_o.st_set = 1'b1;
        cmd_o.st     = ST_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (stat_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

endmodule

### dv/tb_first_fit_heap_allocator.sv
// Self-checking testbench for the first-fit heap allocator.
// Depends on ffha_pkg and first_fit_heap_allocator; predicts every result in-house.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 500;
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_FREE    = 1'b1;

  // Expected result of one transaction.
  typedef struct packed {
    status_e            st;
    logic [START_W-1:0] pay;
    logic [CNT_W-1:0]   act;
    logic [SUM_W-1:0]   asum;
    logic [SUM_W-1:0]   fsum;
  } heap_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [SIZE_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i = 1'b0;
  logic [SIZE_W-1:0]    request_bytes_i = '0;
  logic [START_W-1:0]   release_offset_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [START_W-1:0]   payload_offset_o;
  logic [CNT_W-1:0]     active_count_o;
  logic [SUM_W-1:0]     bytes_allocated_total_o;
  logic [SUM_W-1:0]     bytes_freed_total_o;

  first_fit_heap_allocator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .mode_i, .request_bytes_i, .release_offset_i, .out_valid_o, .out_stall_i,
    .status_o, .payload_offset_o, .active_count_o, .bytes_allocated_total_o,
    .bytes_freed_total_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the allocator state.
  int unsigned  seg_start [MAX_SEGMENTS];
  int unsigned  seg_size  [MAX_SEGMENTS];
  bit           seg_free  [MAX_SEGMENTS];
  int unsigned  seg_count;
  int unsigned  heap_break;
  int unsigned  limit_reg;
  logic [SUM_W-1:0] alloc_total;
  logic [SUM_W-1:0] freed_total;

  heap_result_t pending_results [$];
  int           error_count;
  int           quiet_cycles;
  bit           no_idle;

  // Saturating sum of the running totals.
  function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, int unsigned b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Fold entry k+1 into entry k and close the table gap.
  function automatic void fold_next(int unsigned k);
    seg_size[k] += HEADER_BYTES + seg_size[k+1];
    for (int unsigned j = k + 1; j + 1 < seg_count; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_size[j]  = seg_size[j+1];
      seg_free[j]  = seg_free[j+1];
    end
    seg_count--;
  endfunction

  function automatic status_e alloc_region(int unsigned req, output int unsigned pay);
    int unsigned lim;
    pay = 0;
    if (req == 0) return ST_ZERO_SIZE;
    for (int unsigned i = 0; i < seg_count; i++) begin
      if (seg_free[i] && seg_size[i] >= req) begin
        if (seg_size[i] >= req + 2 * HEADER_BYTES && seg_count < MAX_SEGMENTS) begin
          for (int unsigned j = seg_count; j > i + 1; j--) begin
            seg_start[j] = seg_start[j-1];
            seg_size[j]  = seg_size[j-1];
            seg_free[j]  = seg_free[j-1];
          end
          seg_start[i+1] = seg_start[i] + HEADER_BYTES + req;
          seg_size[i+1]  = seg_size[i] - req - HEADER_BYTES;
          seg_free[i+1]  = 1'b1;
          seg_size[i]    = req;
          seg_count++;
        end
        seg_free[i] = 1'b0;
        alloc_total = add_sat(alloc_total, req);
        pay = seg_start[i] + HEADER_BYTES;
        return ST_OK;
      end
    end
    lim = (limit_reg > ARENA_BYTES) ? ARENA_BYTES : limit_reg;
    if (seg_count >= MAX_SEGMENTS) return ST_NO_SPACE;
    if (heap_break + HEADER_BYTES + req > lim) return ST_NO_SPACE;
    seg_start[seg_count] = heap_break;
    seg_size[seg_count]  = req;
    seg_free[seg_count]  = 1'b0;
    seg_count++;
    heap_break += HEADER_BYTES + req;
    alloc_total = add_sat(alloc_total, req);
    pay = heap_break - req;
    return ST_OK;
  endfunction

  function automatic status_e free_region(int unsigned off);
    int unsigned i;
    if (off == 0) return ST_NULL;
    for (i = 0; i < seg_count; i++)
      if (seg_start[i] + HEADER_BYTES == off) break;
    if (i >= seg_count) return ST_UNKNOWN;
    if (seg_free[i]) return ST_ALREADY_FREE;
    seg_free[i] = 1'b1;
    freed_total = add_sat(freed_total, seg_size[i]);
    if (i + 1 < seg_count && seg_free[i+1]) fold_next(i);
    if (i > 0 && seg_free[i-1]) fold_next(i - 1);
    return ST_OK;
  endfunction

  // Predicts the result of one accepted transaction and updates the shadow.
  function automatic heap_result_t predict_heap(logic mode, int unsigned req,
                                                int unsigned off);
    heap_result_t r;
    int unsigned  pay;
    int unsigned  act;
    pay = 0;
    if (mode == MODE_ALLOC) r.st = alloc_region(req, pay);
    else r.st = free_region(off);
    if (r.st != ST_OK) pay = 0;
    act = 0;
    for (int unsigned i = 0; i < seg_count; i++) if (!seg_free[i]) act++;
    r.pay  = START_W'(pay);
    r.act  = CNT_W'(act);
    r.asum = alloc_total;
    r.fsum = freed_total;
    return r;
  endfunction

  // Mostly short gaps, some medium, a few long.
  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(0, 1);
    if (p < 95) return $urandom_range(2, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Sends one transaction and records its expected result at acceptance.
  task automatic send_item(logic mode, int unsigned req, int unsigned off);
    int g;
    mode_i           <= mode;
    request_bytes_i  <= SIZE_W'(req);
    release_offset_i <= START_W'(off);
    in_valid_i       <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    pending_results.push_back(predict_heap(mode, req & 32'h1FFFFF, off & 32'hFFFFF));
    @(posedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Waits for all results, lets the block settle, then writes the limit.
  task automatic write_limit(int unsigned value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= SIZE_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg   = value & 32'h1FFFFF;
    @(posedge clk_i);
  endtask

  function automatic int unsigned pick_live_offset();
    if (seg_count == 0) return $urandom_range(1, 200);
    return seg_start[$urandom_range(0, seg_count - 1)] + HEADER_BYTES;
  endfunction

  // Zero size, null, unknown, double free, split and whole grants, field extremes.
  task automatic test_special_cases();
    int unsigned a, b;
    send_item(MODE_ALLOC, 0, 0);
    send_item(MODE_FREE, 0, 0);
    send_item(MODE_FREE, 0, 20'hFFFFF);
    send_item(MODE_ALLOC, 1048576, 20'hFFFFF);
    send_item(MODE_ALLOC, 21'h1FFFFF, 0);
    send_item(MODE_ALLOC, 100, 0);
    a = HEADER_BYTES;
    send_item(MODE_ALLOC, 40, 0);
    b = a + 100 + HEADER_BYTES;
    send_item(MODE_ALLOC, 8, 0);
    send_item(MODE_FREE, 0, a);
    send_item(MODE_FREE, 0, a);
    send_item(MODE_FREE, 0, a + 1);
    // Split of the freed 100-byte segment.
    send_item(MODE_ALLOC, 30, 0);
    // The 46-byte remainder is granted whole.
    send_item(MODE_ALLOC, 40, 0);
    send_item(MODE_FREE, 0, b);
    send_item(MODE_FREE, 0, a);
    send_item(MODE_FREE, 0, a + 30 + HEADER_BYTES);
    // Offset merged away by the coalesce.
    send_item(MODE_FREE, 0, b);
    send_item(MODE_ALLOC, 140, 0);
    send_item(MODE_ALLOC, 21'h0FFFFF, 0);
  endtask

  // Limit lowered below the break, at zero and at the register maximum.
  task automatic test_arena_limit();
    write_limit(100);
    send_item(MODE_ALLOC, 1, 0);
    send_item(MODE_ALLOC, 150, 0);
    write_limit(0);
    send_item(MODE_ALLOC, 1, 0);
    write_limit(21'h1FFFFF);
    send_item(MODE_ALLOC, 1048576 - heap_break - HEADER_BYTES + 1, 0);
    send_item(MODE_ALLOC, 64, 0);
    write_limit(1048576);
  endtask

  // Fills the table until it is full, tries one more allocation, then frees offsets picked at random from the table.
  task automatic test_table_full();
    no_idle = 1'b1;
    while (seg_count < MAX_SEGMENTS) send_item(MODE_ALLOC, $urandom_range(1, 16), 0);
    no_idle = 1'b0;
    send_item(MODE_ALLOC, 2000, 0);
    for (int i = 0; i < MAX_SEGMENTS && seg_count > 0; i++)
      send_item(MODE_FREE, 0, pick_live_offset());
  endtask

  // Random mix of allocates and frees, mostly of live offsets.
  task automatic test_random_traffic();
    int p;
    int unsigned req;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 150) write_limit($urandom_range(2000, 1048576));
      no_idle = ((n / 50) % 4 == 3);
      p = $urandom_range(99);
      if (p < 55) begin
        p = $urandom_range(99);
        if (p < 80) req = $urandom_range(1, 200);
        else if (p < 95) req = $urandom_range(1, 8000);
        else req = $urandom_range(0, 21'h1FFFFF);
        send_item(MODE_ALLOC, req, $urandom_range(0, 20'hFFFFF));
      end else begin
        p = $urandom_range(99);
        if (p < 85) send_item(MODE_FREE, $urandom_range(0, 21'h1FFFFF), pick_live_offset());
        else if (p < 90) send_item(MODE_FREE, 0, 0);
        else send_item(MODE_FREE, 0, $urandom_range(0, 20'hFFFFF));
      end
    end
  endtask

  // Result sink stall, changed at the rising edge.
  always @(posedge clk_i) begin
    if (no_idle) out_stall_i <= 1'b0;
    else if ($urandom_range(99) < 3) out_stall_i <= 1'b1;
    else if ($urandom_range(99) < 40) out_stall_i <= ($urandom_range(99) < 30);
  end

  // Result checker and watchdog, sampled mid-cycle.
  always @(negedge clk_i) begin
    heap_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("MISMATCH unexpected result at %0t", $realtime);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o != want.st) report_mismatch("status", status_o, want.st);
          if (payload_offset_o != want.pay)
            report_mismatch("payload_offset", payload_offset_o, want.pay);
          if (active_count_o != want.act)
            report_mismatch("active_count", active_count_o, want.act);
          if (bytes_allocated_total_o != want.asum)
            report_mismatch("bytes_allocated_total", bytes_allocated_total_o, want.asum);
          if (bytes_freed_total_o != want.fsum)
            report_mismatch("bytes_freed_total", bytes_freed_total_o, want.fsum);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    seg_count = 0;
    heap_break = 0;
    limit_reg = 1048576;
    alloc_total = '0;
    freed_total = '0;
    error_count = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_arena_limit();
    test_table_full();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_datapath.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
dv/tb_first_fit_heap_allocator.sv
